>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PPV_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: check failed");
`define PPV_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("%m: never hit");
`else
`define PPV_ASSERT(lbl, clk, rst, prop)
`define PPV_ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

>>> sv/ppv_pkg.sv
package ppv_pkg;
   localparam int CoordW  = 24;
   localparam int RotW    = 18;
   localparam int ProdW   = 42;
   localparam int AccW    = 44;
   localparam int DivBits = 40;
   localparam int TagW    = 16;

   localparam logic [53:0] RotXReset   = 54'h10000;
   localparam logic [53:0] RotYReset   = 54'h4_0000_0000;
   localparam logic [53:0] RotZReset   = 54'h10_0000_0000_0000;
   localparam logic [47:0] FocalReset  = 48'h0001_0000_0100;
   localparam logic [55:0] SizeTolReset = 56'hFF_FFFF_01E0_0280;

   typedef enum logic [1:0] {
      ST_VISIBLE  = 2'd0,
      ST_DEPTH    = 2'd1,
      ST_OUTSIDE  = 2'd2,
      ST_MISMATCH = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      REG_ROT_X     = 3'd0,
      REG_ROT_Y     = 3'd1,
      REG_ROT_Z     = 3'd2,
      REG_TRANS_XY  = 3'd3,
      REG_TRANS_Z   = 3'd4,
      REG_FOCAL     = 3'd5,
      REG_PRINCIPAL = 3'd6,
      REG_SIZE_TOL  = 3'd7
   } reg_index_type;

   typedef logic signed [CoordW-1:0] coord_type;

   typedef struct packed {
      logic [TagW-1:0] point_tag;
      coord_type       world_x;
      coord_type       world_y;
      coord_type       world_z;
      coord_type       expected_depth;
   } point_type;

   typedef struct packed {
      logic [TagW-1:0] result_tag;
      coord_type       cam_x;
      coord_type       cam_y;
      coord_type       cam_z;
      coord_type       norm_x;
      coord_type       norm_y;
      coord_type       pixel_u;
      coord_type       pixel_v;
      status_type      status;
   } result_type;

   typedef struct packed {
      logic [53:0] rot_x;
      logic [53:0] rot_y;
      logic [53:0] rot_z;
      logic [47:0] trans_xy;
      logic [23:0] trans_z;
      logic [47:0] focal;
      logic [47:0] principal;
      logic [55:0] size_tol;
   } cfg_type;

   // item in flight after the pose transform
   typedef struct packed {
      logic [TagW-1:0] tag;
      coord_type       cam_x;
      coord_type       cam_y;
      coord_type       cam_z;
      coord_type       expected_depth;
   } side_type;

   function automatic coord_type sat_coord(input logic signed [33:0] x);
      if (x > 34'sd8388607) begin
         return 24'sh7FFFFF;
      end else if (x < -34'sd8388608) begin
         return 24'sh800000;
      end
      return x[23:0];
   endfunction
endpackage

>>> sv/ppv_stream_if.sv
interface ppv_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

>>> sv/ppv_xform.sv
module ppv_xform (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  ppv_pkg::point_type in_pt,
   input  ppv_pkg::cfg_type   cfg,
   output logic               out_valid,
   output ppv_pkg::side_type  out_side
);
   import ppv_pkg::*;

   logic [53:0] rows [3];
   logic signed [ProdW-1:0] prod_in [3][3];
   logic signed [ProdW-1:0] prod_ff [3][3];
   logic [TagW-1:0] tag1_ff, tag2_ff;
   coord_type ed1_ff, ed2_ff;
   logic signed [CoordW-1:0] tr [3];
   logic signed [AccW-1:0] acc_in [3];
   logic signed [AccW-1:0] acc_ff [3];
   coord_type cam [3];
   logic vld1_ff, vld2_ff, vld3_ff;
   side_type side_ff;

   assign rows[0] = cfg.rot_x;
   assign rows[1] = cfg.rot_y;
   assign rows[2] = cfg.rot_z;
   assign tr[0] = cfg.trans_xy[23:0];
   assign tr[1] = cfg.trans_xy[47:24];
   assign tr[2] = cfg.trans_z;

   always_comb begin
      coord_type w [3];
      w[0] = in_pt.world_x;
      w[1] = in_pt.world_y;
      w[2] = in_pt.world_z;
      for (int r = 0; r < 3; r++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[r][j] = $signed(rows[r][RotW*j +: RotW]) * w[j];
         end
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         acc_in[r] = {{(AccW-40){tr[r][23]}}, tr[r], 16'b0}
                   + {{(AccW-ProdW){prod_ff[r][0][ProdW-1]}}, prod_ff[r][0]}
                   + {{(AccW-ProdW){prod_ff[r][1][ProdW-1]}}, prod_ff[r][1]}
                   + {{(AccW-ProdW){prod_ff[r][2][ProdW-1]}}, prod_ff[r][2]};
      end
   end

   // round half up, floor shift by 16, then clamp
   always_comb begin
      logic signed [AccW-1:0] rnd;
      for (int r = 0; r < 3; r++) begin
         rnd = acc_ff[r] + AccW'(32768);
         cam[r] = sat_coord({{6{rnd[AccW-1]}}, rnd[AccW-1:16]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         tag1_ff <= in_pt.point_tag;
         ed1_ff  <= in_pt.expected_depth;
         acc_ff  <= acc_in;
         tag2_ff <= tag1_ff;
         ed2_ff  <= ed1_ff;
         side_ff.tag            <= tag2_ff;
         side_ff.cam_x          <= cam[0];
         side_ff.cam_y          <= cam[1];
         side_ff.cam_z          <= cam[2];
         side_ff.expected_depth <= ed2_ff;
      end
   end

   assign out_valid = vld3_ff;
   assign out_side  = side_ff;
endmodule

>>> sv/ppv_div.sv
module ppv_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  ppv_pkg::side_type   in_side,
   output logic                out_valid,
   output ppv_pkg::side_type   out_side,
   output ppv_pkg::coord_type  norm_x,
   output ppv_pkg::coord_type  norm_y
);
   import ppv_pkg::*;

   localparam int NB = DivBits;

   logic            vld_ff  [NB+1];
   side_type        side_ff [NB+1];
   logic [NB-1:0]   wrd_ff  [NB+1][2];
   logic [22:0]     rem_ff  [NB+1][2];
   logic            neg_ff  [NB+1][2];
   logic [NB-1:0]   wrd_in  [2];
   coord_type       lane_in [2];
   coord_type       norm    [2];

   assign lane_in[0] = in_side.cam_x;
   assign lane_in[1] = in_side.cam_y;

   // magnitude of cam * 2^16 enters the first stage
   always_comb begin
      logic [23:0] mag;
      for (int l = 0; l < 2; l++) begin
         mag = lane_in[l][23] ? 24'(-lane_in[l]) : 24'(lane_in[l]);
         wrd_in[l] = {mag, 16'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= in_side;
         for (int l = 0; l < 2; l++) begin
            wrd_ff[0][l] <= wrd_in[l];
            rem_ff[0][l] <= '0;
            neg_ff[0][l] <= lane_in[l][23];
         end
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar s = 1; s <= NB; s++) begin : g_stage
      logic [23:0] dvs;
      logic [23:0] tt   [2];
      logic [22:0] rn   [2];
      logic        qb   [2];

      assign dvs = {1'b0, side_ff[s-1].cam_z[22:0]};

      always_comb begin
         for (int l = 0; l < 2; l++) begin
            tt[l] = {rem_ff[s-1][l], wrd_ff[s-1][l][NB-1]};
            qb[l] = (tt[l] >= dvs);
            rn[l] = qb[l] ? 23'(tt[l] - dvs) : tt[l][22:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (adv) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[s] <= side_ff[s-1];
            for (int l = 0; l < 2; l++) begin
               wrd_ff[s][l] <= {wrd_ff[s-1][l][NB-2:0], qb[l]};
               rem_ff[s][l] <= rn[l];
               neg_ff[s][l] <= neg_ff[s-1][l];
            end
         end
      end
   end

   always_comb begin
      logic [NB-1:0] q;
      for (int l = 0; l < 2; l++) begin
         q = wrd_ff[NB][l];
         if (!neg_ff[NB][l]) begin
            norm[l] = (q > NB'(8388607)) ? 24'sh7FFFFF : q[23:0];
         end else begin
            norm[l] = (q >= NB'(8388608)) ? 24'sh800000 : 24'(-q[23:0]);
         end
      end
   end

   assign out_valid = vld_ff[NB];
   assign out_side  = side_ff[NB];
   assign norm_x    = norm[0];
   assign norm_y    = norm[1];
endmodule

>>> sv/ppv_pix.sv
module ppv_pix (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  ppv_pkg::side_type   in_side,
   input  ppv_pkg::coord_type  in_norm_x,
   input  ppv_pkg::coord_type  in_norm_y,
   input  ppv_pkg::cfg_type    cfg,
   output logic                out_valid,
   output ppv_pkg::result_type out_res
);
   import ppv_pkg::*;

   logic vlda_ff, vldb_ff, vldc_ff;
   side_type sidea_ff, sideb_ff;
   coord_type nx_ff, ny_ff, nxb_ff, nyb_ff;
   logic signed [48:0] pu_prod_ff, pv_prod_ff;
   logic [24:0] adiff_ff;
   logic pos_ff;
   logic signed [24:0] diff;
   result_type res_ff, res_in;

   assign diff = {sidea_ff.cam_z[23], sidea_ff.cam_z}
               - {sidea_ff.expected_depth[23], sidea_ff.expected_depth};

   always_comb begin
      logic signed [48:0] ru, rv;
      logic signed [33:0] pu, pv;
      logic [15:0] wd, ht;
      logic outside;
      ru = pu_prod_ff + 49'sd32768;
      rv = pv_prod_ff + 49'sd32768;
      pu = {ru[48], ru[48:16]} + {10'b0, cfg.principal[23:0]};
      pv = {rv[48], rv[48:16]} + {10'b0, cfg.principal[47:24]};
      wd = cfg.size_tol[15:0];
      ht = cfg.size_tol[31:16];
      outside = pu[33] || pv[33]
             || (pu >= $signed({10'b0, wd, 8'b0}))
             || (pv >= $signed({10'b0, ht, 8'b0}));
      res_in.result_tag = sideb_ff.tag;
      res_in.cam_x      = sideb_ff.cam_x;
      res_in.cam_y      = sideb_ff.cam_y;
      res_in.cam_z      = sideb_ff.cam_z;
      if (!pos_ff) begin
         res_in.norm_x  = '0;
         res_in.norm_y  = '0;
         res_in.pixel_u = '0;
         res_in.pixel_v = '0;
         res_in.status  = ST_DEPTH;
      end else begin
         res_in.norm_x  = nxb_ff;
         res_in.norm_y  = nyb_ff;
         res_in.pixel_u = sat_coord(pu);
         res_in.pixel_v = sat_coord(pv);
         if (outside) begin
            res_in.status = ST_OUTSIDE;
         end else if (adiff_ff > {1'b0, cfg.size_tol[55:32]}) begin
            res_in.status = ST_MISMATCH;
         end else begin
            res_in.status = ST_VISIBLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vlda_ff <= 1'b0;
         vldb_ff <= 1'b0;
         vldc_ff <= 1'b0;
      end else if (adv) begin
         vlda_ff <= in_valid;
         vldb_ff <= vlda_ff;
         vldc_ff <= vldb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sidea_ff   <= in_side;
         nx_ff      <= in_norm_x;
         ny_ff      <= in_norm_y;
         sideb_ff   <= sidea_ff;
         nxb_ff     <= nx_ff;
         nyb_ff     <= ny_ff;
         pu_prod_ff <= $signed({1'b0, cfg.focal[23:0]}) * nx_ff;
         pv_prod_ff <= $signed({1'b0, cfg.focal[47:24]}) * ny_ff;
         adiff_ff   <= diff[24] ? 25'(-diff) : 25'(diff);
         pos_ff     <= !sidea_ff.cam_z[23] && (sidea_ff.cam_z != '0);
         res_ff     <= res_in;
      end
   end

   assign out_valid = vldc_ff;
   assign out_res   = res_ff;
endmodule

>>> sv/point_projection_visibility_top.sv
// Pinhole projection of tagged world points. Each beat on req_ch is rotated and
// translated by the pose registers, divided by camera depth, mapped to pixels and
// classified; one result beat leaves on rsp_ch per request beat, in order. One
// point is accepted every cycle while the output is not stalled; the path from
// request beat to result beat is three transform stages, a 41-stage radix-2 divider
// (operand register plus one quotient bit per stage for 40 bits) and three
// pixel/classify stages. A stalled output holds the whole pipeline.
// Registers sit at byte offsets 8*i on the 64-bit APB-style port and must only be
// written while no beat is in flight.
`include "assert_macros.svh"
module point_projection_visibility_top (
   input  logic        clock,
   input  logic        reset,
   ppv_stream_if.sink   req_ch,
   ppv_stream_if.source rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [5:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import ppv_pkg::*;

   cfg_type cfg_ff;
   reg_index_type idx;
   logic wr;
   logic adv;
   logic xf_valid, dv_valid, px_valid;
   side_type xf_side, dv_side;
   coord_type dv_nx, dv_ny;
   result_type px_res;
   logic out_stall, out_depth, depth_fields_zero, out_behind;

   assign csr_pready = 1'b1;
   assign idx = reg_index_type'(csr_paddr[5:3]);
   assign wr  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rot_x     <= RotXReset;
         cfg_ff.rot_y     <= RotYReset;
         cfg_ff.rot_z     <= RotZReset;
         cfg_ff.trans_xy  <= '0;
         cfg_ff.trans_z   <= '0;
         cfg_ff.focal     <= FocalReset;
         cfg_ff.principal <= '0;
         cfg_ff.size_tol  <= SizeTolReset;
      end else if (wr) begin
         case (idx)
            REG_ROT_X:     cfg_ff.rot_x     <= csr_pwdata[53:0];
            REG_ROT_Y:     cfg_ff.rot_y     <= csr_pwdata[53:0];
            REG_ROT_Z:     cfg_ff.rot_z     <= csr_pwdata[53:0];
            REG_TRANS_XY:  cfg_ff.trans_xy  <= csr_pwdata[47:0];
            REG_TRANS_Z:   cfg_ff.trans_z   <= csr_pwdata[23:0];
            REG_FOCAL:     cfg_ff.focal     <= csr_pwdata[47:0];
            REG_PRINCIPAL: cfg_ff.principal <= csr_pwdata[47:0];
            REG_SIZE_TOL:  cfg_ff.size_tol  <= csr_pwdata[55:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_ROT_X:     csr_prdata = {10'b0, cfg_ff.rot_x};
         REG_ROT_Y:     csr_prdata = {10'b0, cfg_ff.rot_y};
         REG_ROT_Z:     csr_prdata = {10'b0, cfg_ff.rot_z};
         REG_TRANS_XY:  csr_prdata = {16'b0, cfg_ff.trans_xy};
         REG_TRANS_Z:   csr_prdata = {40'b0, cfg_ff.trans_z};
         REG_FOCAL:     csr_prdata = {16'b0, cfg_ff.focal};
         REG_PRINCIPAL: csr_prdata = {16'b0, cfg_ff.principal};
         REG_SIZE_TOL:  csr_prdata = {8'b0, cfg_ff.size_tol};
         default:       csr_prdata = '0;
      endcase
   end

   // whole pipeline moves unless a finished beat is waiting
   assign adv          = !px_valid || rsp_ch.ready;
   assign req_ch.ready = adv;

   ppv_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_ch.valid),
      .in_pt     (req_ch.payload),
      .cfg       (cfg_ff),
      .out_valid (xf_valid),
      .out_side  (xf_side)
   );

   ppv_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (xf_valid),
      .in_side   (xf_side),
      .out_valid (dv_valid),
      .out_side  (dv_side),
      .norm_x    (dv_nx),
      .norm_y    (dv_ny)
   );

   ppv_pix u_pix (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (dv_valid),
      .in_side   (dv_side),
      .in_norm_x (dv_nx),
      .in_norm_y (dv_ny),
      .cfg       (cfg_ff),
      .out_valid (px_valid),
      .out_res   (px_res)
   );

   assign rsp_ch.valid   = px_valid;
   assign rsp_ch.payload = px_res;

   assign out_stall         = px_valid && !rsp_ch.ready;
   assign out_depth         = px_valid && (px_res.status == ST_DEPTH);
   assign depth_fields_zero = (px_res.norm_x == '0) && (px_res.pixel_u == '0)
                            && (px_res.pixel_v == '0);
   assign out_behind        = px_res.cam_z[23] || (px_res.cam_z == '0);

   `PPV_ASSERT(a_stall_blocks_input, clock, reset, out_stall |-> !req_ch.ready)
   `PPV_ASSERT(a_depth_zeroes, clock, reset, out_depth |-> depth_fields_zero)
   `PPV_ASSERT_NEVER(a_pos_depth_flag, clock, reset, px_valid && !out_depth && out_behind)
endmodule

>>> sim/point_projection_visibility_top_tb.sv
module point_projection_visibility_top_tb;
   import ppv_pkg::*;

   localparam int Latency = 47;
   localparam int WatchLimit = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   ppv_stream_if #(.payload_type(point_type))  req_ch ();
   ppv_stream_if #(.payload_type(result_type)) rsp_ch ();

   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [5:0]  csr_paddr = '0;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
   end

   point_projection_visibility_top u_dut (
      .clock, .reset, .req_ch, .rsp_ch,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   // model copy of the pose and camera registers
   cfg_type cam_cfg;
   point_type  pending_points[$];
   result_type expected_results[$];
   int mismatches = 0;
   int unexpected = 0;
   int beats_in = 0;
   int beats_out = 0;
   int status_seen[4] = '{0, 0, 0, 0};
   bit calm = 1'b0;
   bit hold_send = 1'b0;
   int idle_cycles = 0;

   task automatic queue_point(point_type p);
      pending_points = {pending_points, p};
   endtask

   function automatic longint sat_q(longint x);
      if (x > 64'sd8388607) return 64'sd8388607;
      if (x < -64'sd8388608) return -64'sd8388608;
      return x;
   endfunction

   function automatic longint floor_round16(longint x);
      return (x + 64'sd32768) >>> 16;
   endfunction

   function automatic longint pose_row(logic [53:0] row, longint wx, longint wy, longint wz,
                                       longint t);
      longint acc;
      acc = t * 65536;
      acc += longint'($signed(row[17:0])) * wx;
      acc += longint'($signed(row[35:18])) * wy;
      acc += longint'($signed(row[53:36])) * wz;
      return sat_q(floor_round16(acc));
   endfunction

   function automatic result_type project_point(point_type p);
      result_type r;
      longint wx, wy, wz, cx, cy, cz, nx, ny, pu, pv, diff, ed;
      longint fx, fy, u0, v0, wd, ht, tol;
      wx = p.world_x;
      wy = p.world_y;
      wz = p.world_z;
      cx = pose_row(cam_cfg.rot_x, wx, wy, wz, longint'($signed(cam_cfg.trans_xy[23:0])));
      cy = pose_row(cam_cfg.rot_y, wx, wy, wz, longint'($signed(cam_cfg.trans_xy[47:24])));
      cz = pose_row(cam_cfg.rot_z, wx, wy, wz, longint'($signed(cam_cfg.trans_z)));
      nx = 0; ny = 0; pu = 0; pv = 0;
      if (cz <= 0) begin
         r.status = ST_DEPTH;
      end else begin
         fx = cam_cfg.focal[23:0];
         fy = cam_cfg.focal[47:24];
         u0 = cam_cfg.principal[23:0];
         v0 = cam_cfg.principal[47:24];
         wd = cam_cfg.size_tol[15:0];
         ht = cam_cfg.size_tol[31:16];
         tol = cam_cfg.size_tol[55:32];
         ed = p.expected_depth;
         nx = sat_q((cx * 65536) / cz);
         ny = sat_q((cy * 65536) / cz);
         pu = floor_round16(fx * nx) + u0;
         pv = floor_round16(fy * ny) + v0;
         diff = cz - ed;
         if (diff < 0) diff = -diff;
         if (pu < 0 || pv < 0 || pu >= wd * 256 || pv >= ht * 256) r.status = ST_OUTSIDE;
         else if (diff > tol) r.status = ST_MISMATCH;
         else r.status = ST_VISIBLE;
         pu = sat_q(pu);
         pv = sat_q(pv);
      end
      r.result_tag = p.point_tag;
      r.cam_x = cx[23:0];
      r.cam_y = cy[23:0];
      r.cam_z = cz[23:0];
      r.norm_x = nx[23:0];
      r.norm_y = ny[23:0];
      r.pixel_u = pu[23:0];
      r.pixel_v = pv[23:0];
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_results = {expected_results, project_point(req_ch.payload)};
            beats_in++;
         end
         if (req_ch.valid && !req_ch.ready) begin
            // beat still waiting: valid and payload stay as they are
         end else if (!hold_send && pending_points.size() > 0 &&
                      (calm || $urandom_range(99) >= 9)) begin
            req_ch.valid <= 1'b1;
            req_ch.payload <= pending_points.pop_front();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= calm || $urandom_range(99) >= 9;
         if (rsp_ch.valid && rsp_ch.ready) begin
            beats_out++;
            if (expected_results.size() == 0) begin
               unexpected++;
               mismatches++;
               if (mismatches <= 10) $display("unexpected result beat %p", rsp_ch.payload);
            end else begin
               result_type exp_r;
               exp_r = expected_results.pop_front();
               status_seen[exp_r.status]++;
               if (rsp_ch.payload !== exp_r) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch tag %0d: expected %p got %p",
                              exp_r.result_tag, exp_r, rsp_ch.payload);
               end
            end
         end
      end
   end

   // watchdog: no beat on either side for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
         $display("timeout: no beat for %0d cycles", WatchLimit);
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic drain();
      wait (pending_points.size() == 0);
      while (!(req_ch.valid == 1'b0 || req_ch.ready)) @(posedge clock);
      @(posedge clock);
      while (req_ch.valid || expected_results.size() > 0) @(posedge clock);
      repeat (Latency + 5) @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, logic [63:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 6'(idx) << 3;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_ROT_X:     cam_cfg.rot_x = value[53:0];
         REG_ROT_Y:     cam_cfg.rot_y = value[53:0];
         REG_ROT_Z:     cam_cfg.rot_z = value[53:0];
         REG_TRANS_XY:  cam_cfg.trans_xy = value[47:0];
         REG_TRANS_Z:   cam_cfg.trans_z = value[23:0];
         REG_FOCAL:     cam_cfg.focal = value[47:0];
         REG_PRINCIPAL: cam_cfg.principal = value[47:0];
         default:       cam_cfg.size_tol = value[55:0];
      endcase
   endtask

   function automatic logic [17:0] q216(int v);
      return v[17:0];
   endfunction

   // a point with a sensible depth: mostly in front, random lateral spread
   function automatic point_type random_point(int spread);
      point_type p;
      p.point_tag = 16'($urandom);
      if (spread == 0) begin
         p.world_x = 24'($urandom);
         p.world_y = 24'($urandom);
         p.world_z = 24'($urandom);
         p.expected_depth = 24'($urandom);
      end else begin
         p.world_x = 24'($signed($urandom_range(2 * spread)) - spread);
         p.world_y = 24'($signed($urandom_range(2 * spread)) - spread);
         p.world_z = 24'($urandom_range(24'h0A0000, 24'h100));
         p.expected_depth = p.world_z + 24'($signed($urandom_range(24'h2000)) - 24'sh1000);
      end
      return p;
   endfunction

   task automatic random_batch(int count);
      int k;
      for (k = 0; k < count; k++) begin
         case ($urandom_range(9))
            0, 1:    queue_point(random_point(0));
            2:       queue_point(random_point(24'h7FFFFF));
            default: queue_point(random_point(24'h40000));
         endcase
      end
   endtask

   task automatic load_random_pose(bit wild);
      logic [63:0] v;
      int e;
      if (wild) begin
         csr_write(REG_ROT_X, {$urandom, $urandom});
         csr_write(REG_ROT_Y, {$urandom, $urandom});
         csr_write(REG_ROT_Z, {$urandom, $urandom});
         csr_write(REG_TRANS_XY, {$urandom, $urandom});
         csr_write(REG_TRANS_Z, {32'h0, $urandom});
         csr_write(REG_FOCAL, {$urandom, $urandom});
         csr_write(REG_PRINCIPAL, {$urandom, $urandom});
         csr_write(REG_SIZE_TOL, {$urandom, $urandom});
      end else begin
         // near-identity rotation with small random terms
         e = $urandom_range(4000);
         csr_write(REG_ROT_X, {10'h0, q216(e - 2000), q216(e - 1000), q216(65536 - e)});
         csr_write(REG_ROT_Y, {10'h0, q216(1500 - e), q216(65536 - e), q216(e - 2000)});
         csr_write(REG_ROT_Z, {10'h0, q216(65536 - e), q216(e - 1000), q216(2000 - e)});
         v = {$urandom, $urandom};
         csr_write(REG_TRANS_XY, {16'h0, 8'(v[31:24] >>> 4), v[23:8], 8'(v[7:0] >>> 4), v[15:0]});
         csr_write(REG_TRANS_Z, {40'h0, 24'($urandom_range(24'h20000))});
         csr_write(REG_FOCAL, {16'h0, 24'($urandom_range(24'h80000, 24'h100)),
                               24'($urandom_range(24'h80000, 24'h100))});
         csr_write(REG_PRINCIPAL, {16'h0, 24'($urandom_range(24'h40000)),
                                   24'($urandom_range(24'h40000))});
         csr_write(REG_SIZE_TOL, {8'h0, 24'($urandom_range(24'h4000)),
                                  16'($urandom_range(4096)), 16'($urandom_range(4096))});
      end
   endtask

   initial begin
      point_type p;
      int phase;
      cam_cfg = '{RotXReset, RotYReset, RotZReset, 48'h0, 24'h0, FocalReset, 48'h0,
                  SizeTolReset};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset pose, edge points
      p = '{16'h0000, 24'sh000000, 24'sh000000, 24'sh010000, 24'sh010000};
      queue_point(p);                                                // on axis, visible
      p = '{16'hFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF};
      queue_point(p);
      p = '{16'h5555, 24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000};
      queue_point(p);                                                // negative depth
      p = '{16'hAAAA, 24'sh010000, 24'sh010000, 24'sh000000, 24'sh000000};
      queue_point(p);                                                // zero depth
      p = '{16'h0001, 24'sh000001, 24'shFFFFFF, 24'sh000001, 24'sh000000};
      queue_point(p);                                                // tiny depth
      p = '{16'h0002, 24'shFF0000, 24'sh000000, 24'sh010000, 24'sh010000};
      queue_point(p);                                                // u below zero
      p = '{16'h0003, 24'sh000000, 24'shFFFF00, 24'sh010000, 24'sh010000};
      queue_point(p);                                                // v below zero
      drain();

      // tight tolerance and image bounds, nonzero principal point
      csr_write(REG_PRINCIPAL, {16'h0, 24'(240 * 256), 24'(320 * 256)});
      csr_write(REG_FOCAL, {16'h0, 24'(300 * 256), 24'(300 * 256)});
      csr_write(REG_SIZE_TOL, {8'h0, 24'h000100, 16'd480, 16'd640});
      p = '{16'h0010, 24'sh000000, 24'sh000000, 24'sh020000, 24'sh020100};
      queue_point(p);                                                // diff equals tol
      p = '{16'h0011, 24'sh000000, 24'sh000000, 24'sh020000, 24'sh020101};
      queue_point(p);                                                // just past tol
      p = '{16'h0012, 24'sh01B556, 24'sh000000, 24'sh020000, 24'sh020000};
      queue_point(p);                                                // near right edge
      p = '{16'h0013, 24'sh000000, 24'sh019999, 24'sh020000, 24'sh020000};
      queue_point(p);                                                // near bottom edge
      p = '{16'h0014, 24'sh400000, 24'sh400000, 24'sh000100, 24'sh000100};
      queue_point(p);                                                // pixel saturates
      drain();

      // zero image size: nothing in front is inside
      csr_write(REG_SIZE_TOL, {8'hFF, 24'hFFFF00, 16'd0, 16'd0});
      csr_write(REG_TRANS_Z, 64'h0000_0000_0080_0000);
      csr_write(REG_TRANS_XY, 64'h0000_7FFF_FF80_0000);
      csr_write(REG_ROT_X, 64'h003F_FFFF_FFFF_FFFF);
      csr_write(REG_ROT_Y, {10'h0, 18'h20000, 18'h20000, 18'h20000});
      csr_write(REG_ROT_Z, {10'h0, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF});
      queue_point('{16'h0020, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh0});
      queue_point('{16'h0021, 24'sh800000, 24'sh800000, 24'sh800000, 24'sh0});
      queue_point('{16'h0022, 24'sh000001, 24'sh000000, 24'sh000000, 24'sh0});
      queue_point('{16'h0023, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh0});
      drain();
      csr_write(REG_FOCAL, 64'h0000_FFFF_FFFF_FFFF);
      csr_write(REG_PRINCIPAL, 64'h0000_FFFF_FFFF_FFFF);
      csr_write(REG_SIZE_TOL, 64'h00FF_FFFF_FFFF_FFFF);
      csr_write(REG_TRANS_Z, 64'h0000_0000_007F_FFFF);
      queue_point('{16'h0024, 24'sh000000, 24'sh000000, 24'sh000000, 24'sh7FFFFF});
      queue_point('{16'h0025, 24'sh010000, 24'shFF0000, 24'sh000000, 24'sh800000});
      drain();

      // random phases over mixed poses; one quiet phase without idling
      for (phase = 0; phase < 8; phase++) begin
         load_random_pose(phase % 3 == 2);
         calm = (phase == 4);
         random_batch(160);
         if (phase == 1) begin
            // sender holds until all in-flight results are back
            wait (pending_points.size() < 80);
            hold_send = 1'b1;
            while (req_ch.valid || expected_results.size() > 0) @(posedge clock);
            hold_send = 1'b0;
         end
         drain();
      end
      calm = 1'b0;

      $display("%0d points sent, %0d results; visible %0d, behind %0d, outside %0d, mismatch %0d",
               beats_in, beats_out, status_seen[0], status_seen[1], status_seen[2],
               status_seen[3]);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches, %0d unexpected, %0d results missing",
                  mismatches, unexpected, expected_results.size());
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

>>> point_projection_visibility_top.f
+incdir+sv
sv/ppv_pkg.sv
sv/ppv_stream_if.sv
sv/ppv_xform.sv
sv/ppv_div.sv
sv/ppv_pix.sv
sv/point_projection_visibility_top.sv
sim/point_projection_visibility_top_tb.sv
